// ===== hw/rtl/etb_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// etb_pkg
// Shared constants and controller/datapath interface types for the
// elimination tree builder.
// ============================================================================
package etb_pkg;

    localparam int MAX_NODES = 1024;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LINK_W    = NODE_W + 1;
    localparam int COUNT_W   = NODE_W + 1;
    localparam int TDATA_W   = ((2 * NODE_W + 7) / 8) * 8;

    // A stored link with its top bit set means the node has no ancestor yet.
    localparam logic [LINK_W-1:0]  LINK_NONE       = {1'b1, {NODE_W{1'b0}}};
    localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = COUNT_W'(MAX_NODES);

    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic lookup;
        logic write_link;
        logic follow;
        logic emit;
    } etb_cmd_t;

    typedef struct packed {
        logic item_ok;
        logic link_none;
        logic link_eq_col;
        logic out_free;
        logic clear_done;
    } etb_status_t;

endpackage

// ===== hw/rtl/etb_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// etb_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module etb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/etb_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// etb_ctrl
// Sequencer for the link memory clearing pass and the ancestor walk.
// ============================================================================
module etb_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  etb_pkg::etb_status_t status,
    output etb_pkg::etb_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_EVAL   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && status.item_ok) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (status.link_none) begin
                    // Wait for the result register before claiming the node.
                    if (status.out_free) begin
                        cmd.write_link = 1'b1;
                        cmd.emit       = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end else if (status.link_eq_col) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.write_link = 1'b1;
                    cmd.follow     = 1'b1;
                    state_next     = ST_LOOKUP;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/etb_dp.sv =====
`timescale 1ns / 1ps
// ============================================================================
// etb_dp
// Datapath: node count register, walk registers, link memory and the
// result register.
// ============================================================================
module etb_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [etb_pkg::TDATA_W-1:0]   s_tdata,
    input  logic                          cfg_valid,
    input  logic [etb_pkg::COUNT_W-1:0]   cfg_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [etb_pkg::TDATA_W-1:0]   m_tdata,
    input  etb_pkg::etb_cmd_t             cmd,
    output etb_pkg::etb_status_t          status
);

    logic [etb_pkg::COUNT_W-1:0] node_count_reg;
    logic [etb_pkg::NODE_W-1:0]  clr_cnt_reg;
    logic [etb_pkg::NODE_W-1:0]  node_reg;
    logic [etb_pkg::NODE_W-1:0]  col_reg;
    logic                        m_valid_reg;
    logic [etb_pkg::NODE_W-1:0]  m_child_reg;
    logic [etb_pkg::NODE_W-1:0]  m_parent_reg;

    logic [etb_pkg::NODE_W-1:0]  in_row;
    logic [etb_pkg::NODE_W-1:0]  in_col;
    logic [etb_pkg::LINK_W-1:0]  link_rdata;
    logic                        ram_we;
    logic [etb_pkg::NODE_W-1:0]  ram_waddr;
    logic [etb_pkg::LINK_W-1:0]  ram_wdata;

    assign in_row = s_tdata[etb_pkg::NODE_W-1:0];
    assign in_col = s_tdata[2*etb_pkg::NODE_W-1:etb_pkg::NODE_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= etb_pkg::NODE_COUNT_RESET;
            clr_cnt_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                node_count_reg <= cfg_data;
            end
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            node_reg <= in_row;
            col_reg  <= in_col;
        end else if (cmd.follow) begin
            node_reg <= link_rdata[etb_pkg::NODE_W-1:0];
        end
        if (cmd.emit) begin
            m_child_reg  <= node_reg;
            m_parent_reg <= col_reg;
        end
    end

    always_comb begin
        ram_we    = cmd.clear_step | cmd.write_link;
        ram_waddr = cmd.clear_step ? clr_cnt_reg : node_reg;
        ram_wdata = cmd.clear_step ? etb_pkg::LINK_NONE : {1'b0, col_reg};
    end

    etb_ram #(
        .WIDTH (etb_pkg::LINK_W),
        .DEPTH (etb_pkg::MAX_NODES)
    ) u_link_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.lookup),
        .raddr (node_reg),
        .rdata (link_rdata)
    );

    always_comb begin
        status.item_ok     = (in_row < in_col) && ({1'b0, in_col} < node_count_reg);
        status.link_none   = link_rdata[etb_pkg::LINK_W-1];
        status.link_eq_col = !link_rdata[etb_pkg::LINK_W-1]
                             && (link_rdata[etb_pkg::NODE_W-1:0] == col_reg);
        status.out_free    = !m_valid_reg || m_tready;
        status.clear_done  = (clr_cnt_reg == etb_pkg::NODE_W'(etb_pkg::MAX_NODES - 1));
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(etb_pkg::TDATA_W - 2*etb_pkg::NODE_W){1'b0}},
                       m_parent_reg, m_child_reg};

endmodule

// ===== hw/rtl/elimination_tree_builder.sv =====
`timescale 1ns / 1ps
// Walk: an accepted entry is loaded, then each ancestor link visited takes a
//   memory read, then a compare and write-back (ST_LOOKUP, then ST_EVAL).
// Input: entries are taken only while idle, so a walk ends before the next
//   entry is taken; an ignored entry is consumed without any walk.
// Reset: synchronous, active low. After reset a clearing pass sets every
//   link to none; no entry is accepted during it.
// ============================================================================
// elimination_tree_builder
// Elimination tree of a symmetric sparse pattern by path-compressed ancestor
// walks. Each transaction on the input carries one upper-pattern nonzero.
// ============================================================================
module elimination_tree_builder (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Input stream. tdata: row_index [9:0], col_index [19:10], zero pad above.
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [etb_pkg::TDATA_W-1:0]  s_tdata,
    // Result stream. tdata: child_node [9:0], parent_node [19:10], zeros above.
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [etb_pkg::TDATA_W-1:0]  m_tdata,
    // Configuration: node_count.
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [etb_pkg::COUNT_W-1:0]  cfg_data
);

    // The controller only sees status flags and issues commands; all index
    // arithmetic and the link memory live in the datapath.
    etb_pkg::etb_cmd_t    cmd;
    etb_pkg::etb_status_t status;

    // The node count register accepts a write in any cycle. Writes are only
    // expected while no walk is in progress.
    assign cfg_ready = 1'b1;

    etb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The result register decouples the output: a new entry is taken while
    // the last result still waits, and a walk that finds a free node stalls
    // only if the previous result has not yet been taken.
    etb_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== hw/rtl/etb_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// etb_checker
// Port-level checks for the elimination tree builder, bound to the top level.
// ============================================================================
module etb_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [etb_pkg::TDATA_W-1:0]  m_tdata
);

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The clearing pass keeps the input closed right after reset.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input open during link clearing");

    // A new result only comes out of a walk, during which input is closed.
    a_result_from_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a walk");

endmodule

bind elimination_tree_builder etb_checker u_etb_checker (.*);
